### src/flash_command_stream_parser_assert.svh
// Assertion macros used by the checker of the flash command stream parser.
`ifndef FLASH_COMMAND_STREAM_PARSER_ASSERT_SVH
`define FLASH_COMMAND_STREAM_PARSER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FCSP_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("fcsp assertion failed");

// A condition that must hold in the cycle after the trigger.
`define FCSP_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("fcsp assertion failed");

`endif

### src/fcsp_pkg.sv
// Package with the types, codes and constants of the flash command stream parser.
package fcsp_pkg;

  localparam int unsigned PageBytesDefault = 256;

  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharI = 8'h49;
  localparam logic [7:0] CharC = 8'h43;

  localparam logic [7:0] CmdReadId   = 8'hF0;
  localparam logic [7:0] CmdStatus   = 8'hF1;
  localparam logic [7:0] CmdRead     = 8'hF2;
  localparam logic [7:0] CmdProgram  = 8'hF3;
  localparam logic [7:0] CmdChipEra  = 8'hF4;
  localparam logic [7:0] CmdEra4k    = 8'hF5;
  localparam logic [7:0] CmdEra32k   = 8'hF6;
  localparam logic [7:0] CmdEra64k   = 8'hF7;

  typedef enum logic [3:0] {
    ACT_READID  = 4'd0,
    ACT_STATUS  = 4'd1,
    ACT_READ    = 4'd2,
    ACT_STORE   = 4'd3,
    ACT_PROGRAM = 4'd4,
    ACT_CHIPERA = 4'd5,
    ACT_ERA4K   = 4'd6,
    ACT_ERA32K  = 4'd7,
    ACT_ERA64K  = 4'd8
  } fcsp_action_e;

  typedef struct packed {
    fcsp_action_e action;
    logic [31:0]  flash_address;
    logic [31:0]  transfer_length;
    logic [7:0]   page_index;
    logic [7:0]   page_byte;
  } fcsp_result_t;

endpackage

### src/fcsp_parser.sv
// Byte-wise command parser: header hunt, command decode and field gathering.
module fcsp_parser import fcsp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic [7:0]   rx_byte_i,
  output logic         res_valid_o,
  output fcsp_result_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GOT_A, ST_GOT_I, ST_GOT_C,
    ST_EADR, ST_RADR, ST_RLEN, ST_PADR, ST_PLEN, ST_PDAT
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] adr_q, adr_d;
  logic [31:0] len_q, len_d;
  logic [8:0]  dcnt_q, dcnt_d;

  logic         emit;
  fcsp_result_t res;
  state_e       hunt;
  logic [31:0]  adr_shift, len_shift;
  logic [8:0]   dcnt_next;
  logic         last_field_byte;

  assign hunt            = (rx_byte_i == CharA) ? ST_GOT_A : ST_IDLE;
  assign adr_shift       = {adr_q[23:0], rx_byte_i};
  assign len_shift       = {len_q[23:0], rx_byte_i};
  assign dcnt_next       = dcnt_q + 9'd1;
  assign last_field_byte = (cnt_q == 2'd3);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    adr_d   = adr_q;
    len_d   = len_q;
    dcnt_d  = dcnt_q;
    emit    = 1'b0;
    res     = '0;
    case (state_q)
      ST_IDLE: state_d = hunt;
      ST_GOT_A: state_d = (rx_byte_i == CharI) ? ST_GOT_I : hunt;
      ST_GOT_I: state_d = (rx_byte_i == CharC) ? ST_GOT_C : hunt;
      ST_GOT_C: begin
        adr_d   = '0;
        len_d   = '0;
        dcnt_d  = '0;
        cnt_d   = '0;
        cmd_d   = rx_byte_i;
        state_d = ST_IDLE;
        case (rx_byte_i)
          CmdReadId: begin
            emit       = 1'b1;
            res.action = ACT_READID;
          end
          CmdStatus: begin
            emit       = 1'b1;
            res.action = ACT_STATUS;
          end
          CmdRead:    state_d = ST_RADR;
          CmdProgram: state_d = ST_PADR;
          CmdChipEra: begin
            emit       = 1'b1;
            res.action = ACT_CHIPERA;
          end
          CmdEra4k, CmdEra32k, CmdEra64k: state_d = ST_EADR;
          // An unknown command byte may itself open a new header.
          default: state_d = hunt;
        endcase
      end
      ST_EADR, ST_RADR, ST_PADR: begin
        adr_d = adr_shift;
        cnt_d = cnt_q + 2'd1;
        if (last_field_byte) begin
          if (state_q == ST_EADR) begin
            emit              = 1'b1;
            res.flash_address = adr_shift;
            res.action        = (cmd_q == CmdEra4k)  ? ACT_ERA4K  :
                                (cmd_q == CmdEra32k) ? ACT_ERA32K : ACT_ERA64K;
            state_d           = ST_IDLE;
          end else if (state_q == ST_RADR) begin
            state_d = ST_RLEN;
          end else begin
            state_d = ST_PLEN;
          end
        end
      end
      ST_RLEN, ST_PLEN: begin
        len_d = len_shift;
        cnt_d = cnt_q + 2'd1;
        if (last_field_byte) begin
          if (state_q == ST_RLEN) begin
            emit                = 1'b1;
            res.action          = ACT_READ;
            res.flash_address   = adr_q;
            res.transfer_length = len_shift;
            state_d             = ST_IDLE;
          end else begin
            // Program lengths beyond one page are cut back to a page.
            if (len_shift > 32'(PAGE_BYTES)) begin
              len_d = 32'(PAGE_BYTES);
            end
            state_d = ST_PDAT;
          end
        end
      end
      ST_PDAT: begin
        dcnt_d              = dcnt_next;
        emit                = 1'b1;
        res.flash_address   = adr_q;
        res.transfer_length = len_q;
        res.page_index      = dcnt_q[7:0];
        res.page_byte       = rx_byte_i;
        if ({23'd0, dcnt_next} >= len_q) begin
          res.action = ACT_PROGRAM;
          state_d    = ST_IDLE;
        end else begin
          res.action = ACT_STORE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_valid_o = fire_i & emit;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cmd_q   <= '0;
      adr_q   <= '0;
      len_q   <= '0;
      dcnt_q  <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      adr_q   <= adr_d;
      len_q   <= len_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

### src/fcsp_out_buf.sv
// Output register with a skid stage for result beats.
module fcsp_out_buf import fcsp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  input  fcsp_result_t res_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output fcsp_result_t out_o,
  output logic         full_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  fcsp_result_t out_q, skid_q;
  logic         out_load, skid_load;

  // The output register takes a beat whenever it is empty or being drained.
  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    skid_load    = 1'b0;
    if (out_load) begin
      out_valid_d  = skid_valid_q || res_valid_i;
      skid_valid_d = 1'b0;
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_load    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end
    if (skid_load) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign full_o      = skid_valid_q;

endmodule

### src/flash_command_stream_parser.sv
// Top level of the flash command stream parser: byte parser and result buffer.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   rx_byte_i
//   result   out        out_valid_o / out_ready_i action_o, flash_address_o,
//                                                 transfer_length_o, page_index_o, page_byte_o
//
// A byte beat is taken per cycle unless the input stalls; its result, if any, is registered.
// The parse step is a single pass through the state decoder into the result register.
// A skid stage behind the result register holds one more result, so the input
// stalls only when both the result register and the skid stage are occupied.
// Reset (rst_ni low, asynchronous) returns the parser to header hunting.
module flash_command_stream_parser import fcsp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [31:0] flash_address_o,
  output logic [31:0] transfer_length_o,
  output logic [7:0]  page_index_o,
  output logic [7:0]  page_byte_o
);

  logic         fire;
  logic         res_valid;
  logic         buf_full;
  fcsp_result_t res;
  fcsp_result_t out;

  assign in_ready_o = !buf_full;
  assign fire       = in_valid_i && in_ready_o;

  fcsp_parser #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  fcsp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_o      (out),
    .full_o     (buf_full)
  );

  assign action_o          = out.action;
  assign flash_address_o   = out.flash_address;
  assign transfer_length_o = out.transfer_length;
  assign page_index_o      = out.page_index;
  assign page_byte_o       = out.page_byte;

endmodule

### src/fcsp_checker.sv
// Port-level checker for the flash command stream parser, with its bind.
`include "flash_command_stream_parser_assert.svh"

module fcsp_checker import fcsp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  action_o,
  input logic [31:0] flash_address_o,
  input logic [31:0] transfer_length_o,
  input logic [7:0]  page_index_o,
  input logic [7:0]  page_byte_o
);

  logic        no_payload_act;
  logic        payload_zero;
  logic [83:0] payload;

  assign no_payload_act = (action_o == ACT_READID) || (action_o == ACT_STATUS) ||
                          (action_o == ACT_CHIPERA);
  assign payload_zero   = (flash_address_o == '0) && (transfer_length_o == '0) &&
                          (page_index_o == '0) && (page_byte_o == '0);
  assign payload        = {action_o, flash_address_o, transfer_length_o,
                           page_index_o, page_byte_o};

  `FCSP_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)
  `FCSP_ASSERT_NEXT(a_out_payload_holds, out_valid_o && !out_ready_i, $stable(payload))
  `FCSP_ASSERT_NOW(a_action_in_range, !out_valid_o || (action_o <= ACT_ERA64K))
  `FCSP_ASSERT_NOW(a_plain_action_zero, !(out_valid_o && no_payload_act) || payload_zero)
  // The input can only stall while a result is waiting on the output.
  `FCSP_ASSERT_NOW(a_ready_when_empty, out_valid_o || in_ready_o)

endmodule

bind flash_command_stream_parser fcsp_checker u_fcsp_checker (.*);
